@@ rtl/core/small_matrix_inverse_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the small matrix inverse block
// Implication checks, clocked on clk and quiet while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef SMALL_MATRIX_INVERSE_MACROS_SVH
`define SMALL_MATRIX_INVERSE_MACROS_SVH

// same-cycle implication
`define SMI_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("smi assertion failed");

// next-cycle implication
`define SMI_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("smi assertion failed");

`endif

@@ rtl/core/smi_pkg.sv @@
// ----------------------------------------------------------------------------
// smi_pkg
// Widths, stage counts and cofactor product table for the matrix inverse.
// ----------------------------------------------------------------------------
package smi_pkg;

	localparam int DW   = 32;            // entry width
	localparam int FB   = 16;            // fraction bits
	localparam int PW   = 2 * DW;        // entry product
	localparam int CW   = PW + 1;        // cofactor
	localparam int HW   = CW;            // partial product of entry by cofactor half
	localparam int DETW = 3 * DW + 2;    // determinant
	localparam int QB   = DW;            // quotient bits
	localparam int DDW  = DETW + 1;      // doubled divisor
	localparam int NW   = DETW + QB + 2; // dividend / remainder
	localparam int NPRE = 7;             // stages ahead of the divider
	localparam int DST  = QB + 1;        // divider stages (range check + one per bit)
	localparam int NST  = NPRE + DST + 1;
	localparam int NPROD = 18;

	typedef enum logic [1:0] {
		SZ_NONE  = 2'd0,
		SZ_ONE   = 2'd1,
		SZ_TWO   = 2'd2,
		SZ_THREE = 2'd3
	} size_t;

	typedef logic signed [DW-1:0]   ent_t;
	typedef logic signed [PW-1:0]   prod_t;
	typedef logic signed [CW-1:0]   cof_t;
	typedef logic signed [HW-1:0]   part_t;
	typedef logic signed [DETW-1:0] det_t;

	// cofactor j = e[PA[2j]]*e[PB[2j]] - e[PA[2j+1]]*e[PB[2j+1]]
	localparam int unsigned PA [NPROD] = '{4, 5, 2, 1, 1, 2, 5, 3, 0, 2, 2, 0, 3, 4, 1, 0, 0, 1};
	localparam int unsigned PB [NPROD] = '{8, 7, 7, 8, 5, 4, 6, 8, 8, 6, 3, 5, 7, 6, 6, 7, 4, 3};

endpackage

@@ rtl/core/smi_div.sv @@
// ----------------------------------------------------------------------------
// smi_div
// Pipelined restoring divider lane: range check, then one quotient bit a stage.
// ----------------------------------------------------------------------------
module smi_div import smi_pkg::*; (
	input  logic           clk,
	input  logic [DST-1:0] ld,
	input  logic [NW-1:0]  num,
	input  logic [DDW-1:0] den2,
	input  logic           neg,
	output logic [QB-1:0]  quo,
	output logic           ovf,
	output logic           neg_o
);

	logic [NW-1:0]  rem_s [DST];
	logic [DDW-1:0] dv_s  [DST];
	logic [QB-1:0]  quo_s [DST];
	logic           ovf_s [DST];
	logic           neg_s [DST];

	// quotient of 2^QB or more sets ovf
	always_ff @(posedge clk) begin
		if (ld[0]) begin
			rem_s[0] <= num;
			dv_s[0]  <= den2;
			quo_s[0] <= '0;
			ovf_s[0] <= num >= ({{(NW-DDW){1'b0}}, den2} << QB);
			neg_s[0] <= neg;
		end
	end

	for (genvar k = 1; k < DST; k++) begin : g_step
		localparam int B = QB - k;
		logic [NW-1:0] dsh;
		logic          ge;

		always_comb begin
			dsh = {{(NW-DDW){1'b0}}, dv_s[k-1]} << B;
			ge  = rem_s[k-1] >= dsh;
		end

		always_ff @(posedge clk) begin
			if (ld[k]) begin
				rem_s[k] <= ge ? rem_s[k-1] - dsh : rem_s[k-1];
				quo_s[k] <= quo_s[k-1] | ({{(QB-1){1'b0}}, ge} << B);
				dv_s[k]  <= dv_s[k-1];
				ovf_s[k] <= ovf_s[k-1];
				neg_s[k] <= neg_s[k-1];
			end
		end
	end

	assign quo   = quo_s[DST-1];
	assign ovf   = ovf_s[DST-1];
	assign neg_o = neg_s[DST-1];

endmodule

@@ rtl/core/small_matrix_inverse.sv @@
// Throughput: one matrix per cycle while in_stall is low; every stage is a
//   register, and the 33-stage divider lanes (a range check, then one quotient
//   bit per stage) set the depth.
// A held result stalls only the stages behind it that are full; bubbles close up.
// Reset (arst_n low, asynchronous) clears all stage valid bits; data is not reset.
// ----------------------------------------------------------------------------
// small_matrix_inverse
// 1x1, 2x2 or 3x3 Q16.16 inverse by adjugate over determinant, with
// round-to-nearest (ties away), saturation and singular detection.
// ----------------------------------------------------------------------------
`include "small_matrix_inverse_macros.svh"

module small_matrix_inverse import smi_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [1:0]          size,
	input  logic signed [DW-1:0] a11,
	input  logic signed [DW-1:0] a12,
	input  logic signed [DW-1:0] a13,
	input  logic signed [DW-1:0] a21,
	input  logic signed [DW-1:0] a22,
	input  logic signed [DW-1:0] a23,
	input  logic signed [DW-1:0] a31,
	input  logic signed [DW-1:0] a32,
	input  logic signed [DW-1:0] a33,
	output logic                out_valid,
	input  logic                out_stall,
	output logic signed [DW-1:0] r11,
	output logic signed [DW-1:0] r12,
	output logic signed [DW-1:0] r13,
	output logic signed [DW-1:0] r21,
	output logic signed [DW-1:0] r22,
	output logic signed [DW-1:0] r23,
	output logic signed [DW-1:0] r31,
	output logic signed [DW-1:0] r32,
	output logic signed [DW-1:0] r33,
	output logic                singular,
	output logic                saturated
);

	// ---------------- flow control ----------------
	// vld_q index: 0..6 front stages, 7..39 divider, 40 output register
	logic [NST-1:0] vld_q;
	logic [NST:0]   rdy;

	always_comb begin
		rdy[NST] = !out_stall;
		for (int i = NST - 1; i >= 0; i--) begin
			rdy[i] = !vld_q[i] || rdy[i+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int i = 0; i < NST; i++) begin
				if (rdy[i]) begin
					vld_q[i] <= (i == 0) ? in_valid : vld_q[(i == 0) ? 0 : i - 1];
				end
			end
		end
	end

	assign in_stall  = !rdy[0];
	assign out_valid = vld_q[NST-1];

	// ---------------- s1: capture ----------------
	size_t size_s1;
	ent_t  e_s1 [9];

	always_ff @(posedge clk) begin
		if (rdy[0]) begin
			size_s1 <= size_t'(size);
			e_s1[0] <= a11; e_s1[1] <= a12; e_s1[2] <= a13;
			e_s1[3] <= a21; e_s1[4] <= a22; e_s1[5] <= a23;
			e_s1[6] <= a31; e_s1[7] <= a32; e_s1[8] <= a33;
		end
	end

	// ---------------- s2: 18 entry products ----------------
	size_t size_s2;
	ent_t  e_s2 [9];
	prod_t prod_s2 [NPROD];

	always_ff @(posedge clk) begin
		if (rdy[1]) begin
			size_s2 <= size_s1;
			e_s2    <= e_s1;
			for (int k = 0; k < NPROD; k++) begin
				prod_s2[k] <= e_s1[PA[k]] * e_s1[PB[k]];
			end
		end
	end

	// ---------------- s3: cofactors, chosen by order ----------------
	cof_t  x_w [9];
	cof_t  cf_w [9];
	size_t size_s3;
	cof_t  cf_s3 [9];
	cof_t  x8_s3;
	ent_t  et_s3 [3];

	always_comb begin
		for (int j = 0; j < 9; j++) begin
			x_w[j]  = CW'(prod_s2[2*j]) - CW'(prod_s2[2*j+1]);
			cf_w[j] = '0;
		end
		case (size_s2)
			SZ_ONE: begin
				cf_w[0] = CW'(1);
			end
			SZ_TWO: begin
				cf_w[0] = CW'(e_s2[4]);
				cf_w[1] = -CW'(e_s2[1]);
				cf_w[3] = -CW'(e_s2[3]);
				cf_w[4] = CW'(e_s2[0]);
			end
			SZ_THREE: begin
				cf_w = x_w;
			end
			default: begin
				cf_w[0] = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (rdy[2]) begin
			size_s3 <= size_s2;
			cf_s3   <= cf_w;
			x8_s3   <= x_w[8];
			et_s3[0] <= e_s2[0];
			et_s3[1] <= e_s2[1];
			et_s3[2] <= e_s2[2];
		end
	end

	// ---------------- s4: first row times cofactors, split in halves ----------------
	size_t size_s4;
	cof_t  cf_s4 [9];
	cof_t  x8_s4;
	ent_t  e0_s4;
	part_t plo_s4 [3];
	part_t phi_s4 [3];

	always_ff @(posedge clk) begin
		if (rdy[3]) begin
			size_s4 <= size_s3;
			cf_s4   <= cf_s3;
			x8_s4   <= x8_s3;
			e0_s4   <= et_s3[0];
			for (int t = 0; t < 3; t++) begin
				plo_s4[t] <= et_s3[t] * $signed({1'b0, cf_s3[3*t][DW-1:0]});
				phi_s4[t] <= et_s3[t] * $signed(cf_s3[3*t][CW-1:DW]);
			end
		end
	end

	// ---------------- s5: merge halves ----------------
	size_t size_s5;
	cof_t  cf_s5 [9];
	cof_t  x8_s5;
	ent_t  e0_s5;
	det_t  pt_s5 [3];

	always_ff @(posedge clk) begin
		if (rdy[4]) begin
			size_s5 <= size_s4;
			cf_s5   <= cf_s4;
			x8_s5   <= x8_s4;
			e0_s5   <= e0_s4;
			for (int t = 0; t < 3; t++) begin
				pt_s5[t] <= (DETW'(phi_s4[t]) <<< DW) + DETW'(plo_s4[t]);
			end
		end
	end

	// ---------------- s6: denominator ----------------
	det_t den_w;
	det_t den_s6;
	cof_t cf_s6 [9];

	always_comb begin
		case (size_s5)
			SZ_ONE:   den_w = DETW'(e0_s5);
			SZ_TWO:   den_w = DETW'(x8_s5);
			SZ_THREE: den_w = pt_s5[0] + pt_s5[1] + pt_s5[2];
			default:  den_w = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (rdy[5]) begin
			den_s6 <= den_w;
			cf_s6  <= cf_s5;
		end
	end

	// ---------------- s7: magnitudes and rounded dividends ----------------
	// q = floor((2*|cf|*2^(2FB) + |den|) / (2*|den|))
	logic [DETW-1:0] aden_w;
	logic [NW-1:0]   num_s7 [9];
	logic [DDW-1:0]  d2_s7;
	logic            neg_s7 [9];
	logic            sing_s7;

	assign aden_w = den_s6[DETW-1] ? DETW'(-den_s6) : DETW'(den_s6);

	always_ff @(posedge clk) begin
		if (rdy[6]) begin
			d2_s7   <= {aden_w, 1'b0};
			sing_s7 <= den_s6 == '0;
			for (int j = 0; j < 9; j++) begin
				num_s7[j] <= (NW'(cf_s6[j][CW-1] ? CW'(-cf_s6[j]) : CW'(cf_s6[j]))
					<< (2*FB + 1)) + NW'(aden_w);
				neg_s7[j] <= cf_s6[j][CW-1] ^ den_s6[DETW-1];
			end
		end
	end

	// ---------------- divider lanes ----------------
	logic [QB-1:0] quo_w [9];
	logic          ovf_w [9];
	logic          neg_w [9];
	logic          sing_d [DST];

	for (genvar j = 0; j < 9; j++) begin : g_lane
		smi_div u_div (
			.clk   (clk),
			.ld    (rdy[NPRE +: DST]),
			.num   (num_s7[j]),
			.den2  (d2_s7),
			.neg   (neg_s7[j]),
			.quo   (quo_w[j]),
			.ovf   (ovf_w[j]),
			.neg_o (neg_w[j])
		);
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < DST; k++) begin
			if (rdy[NPRE + k]) begin
				sing_d[k] <= (k == 0) ? sing_s7 : sing_d[(k == 0) ? 0 : k - 1];
			end
		end
	end

	// ---------------- s8: saturate, sign, output register ----------------
	logic [DW-1:0] res_w [9];
	logic          sat_w;
	logic [DW-1:0] res_s8 [9];
	logic          sing_s8;
	logic          sat_s8;

	always_comb begin
		logic [QB-1:0] lim;
		logic [QB-1:0] mag;
		logic          clip;
		sat_w = 1'b0;
		for (int j = 0; j < 9; j++) begin
			lim  = neg_w[j] ? {1'b1, {(QB-1){1'b0}}} : {1'b0, {(QB-1){1'b1}}};
			clip = ovf_w[j] || (quo_w[j] > lim);
			mag  = clip ? lim : quo_w[j];
			res_w[j] = sing_d[DST-1] ? '0 : (neg_w[j] ? -mag : mag);
			sat_w = sat_w | (clip & !sing_d[DST-1]);
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[NST-1]) begin
			res_s8  <= res_w;
			sing_s8 <= sing_d[DST-1];
			sat_s8  <= sat_w;
		end
	end

	assign r11 = res_s8[0];
	assign r12 = res_s8[1];
	assign r13 = res_s8[2];
	assign r21 = res_s8[3];
	assign r22 = res_s8[4];
	assign r23 = res_s8[5];
	assign r31 = res_s8[6];
	assign r32 = res_s8[7];
	assign r33 = res_s8[8];
	assign singular  = sing_s8;
	assign saturated = sat_s8;

	// ---------------- checks ----------------
	`SMI_ASSERT_IMP(a_sing_zero, out_valid && singular,
		!saturated && r11 == 0 && r12 == 0 && r13 == 0 && r21 == 0 && r22 == 0 &&
		r23 == 0 && r31 == 0 && r32 == 0 && r33 == 0)
	`SMI_ASSERT_IMP(a_stall_cause, in_stall, out_valid && out_stall)
	`SMI_ASSERT_IMP(a_stall_full, in_stall, &vld_q)

endmodule

@@ tb/small_matrix_inverse_tb.sv @@
// ----------------------------------------------------------------------------
// small_matrix_inverse_tb
// Drives 1x1, 2x2 and 3x3 Q16.16 matrices (plus the degenerate size zero)
// through the inverse pipeline under several idle and stall mixes, predicts
// each inverse with wide exact integer arithmetic, and checks every result
// field by field in arrival order.
// ----------------------------------------------------------------------------
module small_matrix_inverse_tb import smi_pkg::*; ();

	localparam int WW = 200;          // wide enough for det << 33 and more
	localparam int TAIL = 60;         // settle time past the pipeline latency

	typedef logic signed [WW-1:0] wide_t;

	typedef struct {
		size_t sz;
		ent_t  a [9];
	} matrix_t;

	typedef struct {
		ent_t r [9];
		logic singular;
		logic saturated;
	} inverse_t;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	logic [1:0] size = '0;
	ent_t a11 = '0, a12 = '0, a13 = '0, a21 = '0, a22 = '0;
	ent_t a23 = '0, a31 = '0, a32 = '0, a33 = '0;
	logic out_valid;
	logic out_stall = 1;
	ent_t r11, r12, r13, r21, r22, r23, r31, r32, r33;
	logic singular, saturated;

	matrix_t  pending_mats [$];       // items waiting to be offered
	inverse_t expected_invs [$];      // predicted inverses in accept order
	matrix_t  cur_mat;                // item now on the input port
	int       tx_idle_pct = 0;
	int       rx_stall_pct = 0;
	bit       hold_req = 0;           // toggled to ask for a long output hold
	bit       hold_ack = 0;
	int       hold_cnt = 0;
	int       errors = 0;

	always #4 clk = ~clk;

	small_matrix_inverse dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .size(size),
		.a11(a11), .a12(a12), .a13(a13), .a21(a21), .a22(a22),
		.a23(a23), .a31(a31), .a32(a32), .a33(a33),
		.out_valid(out_valid), .out_stall(out_stall),
		.r11(r11), .r12(r12), .r13(r13), .r21(r21), .r22(r22),
		.r23(r23), .r31(r31), .r32(r32), .r33(r33),
		.singular(singular), .saturated(saturated)
	);

	// Exact quotient cof * 2^32 / den, rounded half away from zero, clipped.
	function automatic ent_t fixed_quotient(wide_t cof, wide_t den, ref logic sat);
		logic  neg;
		wide_t num, dm, q, lim, v;
		neg = (cof < 0) != (den < 0);
		num = (cof < 0) ? -cof : cof;
		dm  = (den < 0) ? -den : den;
		q   = ((num <<< (2 * FB + 1)) + dm) / (dm <<< 1);
		lim = neg ? (wide_t'(1) <<< (DW - 1)) : (wide_t'(1) <<< (DW - 1)) - 1;
		if (q > lim) begin
			sat = 1;
			q = lim;
		end
		v = neg ? -q : q;
		return v[DW-1:0];
	endfunction

	// Adjugate over determinant; cofactor signs match the PA/PB table in smi_pkg.
	function automatic inverse_t invert(matrix_t m);
		wide_t    e [9];
		wide_t    cf [9];
		wide_t    den;
		inverse_t res;
		logic     sat;
		sat = 0;
		den = 0;
		for (int i = 0; i < 9; i++) begin
			e[i] = m.a[i];
			cf[i] = 0;
			res.r[i] = '0;
		end
		res.singular = 0;
		res.saturated = 0;
		case (m.sz)
			SZ_ONE: begin
				cf[0] = 1;
				den = e[0];
			end
			SZ_TWO: begin
				cf[0] = e[4];
				cf[1] = -e[1];
				cf[3] = -e[3];
				cf[4] = e[0];
				den = e[0] * e[4] - e[1] * e[3];
			end
			SZ_THREE: begin
				cf[0] = e[4] * e[8] - e[5] * e[7];
				cf[1] = e[2] * e[7] - e[1] * e[8];
				cf[2] = e[1] * e[5] - e[2] * e[4];
				cf[3] = e[5] * e[6] - e[3] * e[8];
				cf[4] = e[0] * e[8] - e[2] * e[6];
				cf[5] = e[2] * e[3] - e[0] * e[5];
				cf[6] = e[3] * e[7] - e[4] * e[6];
				cf[7] = e[1] * e[6] - e[0] * e[7];
				cf[8] = e[0] * e[4] - e[1] * e[3];
				den = e[0] * cf[0] + e[1] * cf[3] + e[2] * cf[6];
			end
			default: den = 0;   // size zero is not a matrix
		endcase
		if (den == 0) begin
			res.singular = 1;
			return res;
		end
		for (int i = 0; i < 9; i++)
			res.r[i] = fixed_quotient(cf[i], den, sat);
		res.saturated = sat;
		return res;
	endfunction

	function automatic ent_t rand_full();
		return ent_t'($urandom);
	endfunction

	// entries within +/-4.0 keep most inverses in range
	function automatic ent_t rand_mid();
		return ent_t'(int'($urandom_range(0, 1 << 19)) - (1 << 18));
	endfunction

	function automatic matrix_t rand_matrix();
		matrix_t m;
		int      kind;
		int      pick;
		pick = $urandom_range(0, 99);
		if (pick < 4)       m.sz = SZ_NONE;
		else if (pick < 30) m.sz = SZ_ONE;
		else if (pick < 62) m.sz = SZ_TWO;
		else                m.sz = SZ_THREE;
		kind = $urandom_range(0, 9);
		for (int i = 0; i < 9; i++)
			m.a[i] = (kind < 6) ? rand_mid() : rand_full();
		// small integer entries: exact and often singular
		if (kind == 9)
			for (int i = 0; i < 9; i++)
				m.a[i] = ent_t'(int'($urandom_range(0, 4)) - 2) <<< FB;
		// repeated row makes a singular matrix
		if (kind == 8 && m.sz == SZ_THREE)
			for (int i = 0; i < 3; i++)
				m.a[6 + i] = m.a[i];
		if (kind == 8 && m.sz == SZ_TWO) begin
			m.a[3] = m.a[0];
			m.a[4] = m.a[1];
		end
		return m;
	endfunction

	function automatic matrix_t make_mat(size_t sz, int v0, int v1, int v2, int v3,
			int v4, int v5, int v6, int v7, int v8);
		matrix_t m;
		m.sz = sz;
		m.a = '{v0, v1, v2, v3, v4, v5, v6, v7, v8};
		return m;
	endfunction

	// append an item to the pending list
	task automatic queue_mat(matrix_t m);
		pending_mats.insert(pending_mats.size(), m);
	endtask

	// Driver: on accept, record the prediction, then offer the next item or idle.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 0;
		end else begin
			if (in_valid && !in_stall)
				expected_invs.insert(expected_invs.size(), invert(cur_mat));
			if (!in_valid || !in_stall) begin
				if (pending_mats.size() == 0 || $urandom_range(0, 99) < tx_idle_pct) begin
					in_valid <= 0;
				end else begin
					cur_mat = pending_mats.pop_front();
					in_valid <= 1;
					size <= cur_mat.sz;
					a11 <= cur_mat.a[0];
					a12 <= cur_mat.a[1];
					a13 <= cur_mat.a[2];
					a21 <= cur_mat.a[3];
					a22 <= cur_mat.a[4];
					a23 <= cur_mat.a[5];
					a31 <= cur_mat.a[6];
					a32 <= cur_mat.a[7];
					a33 <= cur_mat.a[8];
				end
			end
		end
	end

	// Monitor: compare accepted results, then pick the next stall value.
	always @(posedge clk or negedge arst_n) begin
		inverse_t want;
		ent_t     got [9];
		if (!arst_n) begin
			out_stall <= 1;
		end else begin
			if (out_valid && !out_stall) begin
				got = '{r11, r12, r13, r21, r22, r23, r31, r32, r33};
				if (expected_invs.size() == 0) begin
					$display("%0t: result with nothing expected", $time);
					errors++;
				end else begin
					want = expected_invs.pop_front();
					for (int i = 0; i < 9; i++)
						if (got[i] !== want.r[i]) begin
							$display("%0t: r%0d%0d expected %h actual %h", $time,
								i / 3 + 1, i % 3 + 1, want.r[i], got[i]);
							errors++;
						end
					if (singular !== want.singular) begin
						$display("%0t: singular expected %b actual %b", $time,
							want.singular, singular);
						errors++;
					end
					if (saturated !== want.saturated) begin
						$display("%0t: saturated expected %b actual %b", $time,
							want.saturated, saturated);
						errors++;
					end
				end
			end
			// long hold lets the pipe fill and push back on the input
			if (hold_cnt != 0) begin
				hold_cnt <= hold_cnt - 1;
				out_stall <= 1;
			end else if (hold_req != hold_ack) begin
				hold_ack <= hold_req;
				hold_cnt <= 300;
				out_stall <= 1;
			end else begin
				out_stall <= ($urandom_range(0, 99) < rx_stall_pct);
			end
		end
	end

	task automatic wait_drained();
		while (pending_mats.size() != 0 || in_valid || expected_invs.size() != 0)
			@(negedge clk);
	endtask

	task automatic run_phase(int n, int tx_pct, int rx_pct);
		@(negedge clk);
		tx_idle_pct = tx_pct;
		rx_stall_pct = rx_pct;
		for (int i = 0; i < n; i++)
			queue_mat(rand_matrix());
		wait_drained();
	endtask

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed: reciprocal edges, identities, singular cases, size zero
		queue_mat(make_mat(SZ_ONE, 32'h0001_0000, 0, 0, 0, 0, 0, 0, 0, 0));
		queue_mat(make_mat(SZ_ONE, 32'hFFFF_0000, -1, -1, -1, -1, -1, -1, -1, -1));
		queue_mat(make_mat(SZ_ONE, 0, 5, 5, 5, 5, 5, 5, 5, 5));
		queue_mat(make_mat(SZ_ONE, 1, 0, 0, 0, 0, 0, 0, 0, 0));
		queue_mat(make_mat(SZ_ONE, -1, 0, 0, 0, 0, 0, 0, 0, 0));
		queue_mat(make_mat(SZ_ONE, 32'h7FFF_FFFF, 0, 0, 0, 0, 0, 0, 0, 0));
		queue_mat(make_mat(SZ_ONE, 32'h8000_0000, 0, 0, 0, 0, 0, 0, 0, 0));
		queue_mat(make_mat(SZ_ONE, 32'h0003_0000, 0, 0, 0, 0, 0, 0, 0, 0));
		queue_mat(make_mat(SZ_ONE, 2, 0, 0, 0, 0, 0, 0, 0, 0));
		queue_mat(make_mat(SZ_TWO, 32'h0001_0000, 7, 9, 0, 32'h0001_0000,
			9, 9, 9, 9));
		queue_mat(make_mat(SZ_TWO, 32'h0002_0000, 32'h0004_0000, 0,
			32'h0001_0000, 32'h0002_0000, 0, 0, 0, 0));
		queue_mat(make_mat(SZ_TWO, 32'h0004_0000, 32'h0007_0000, 0,
			32'h0002_0000, 32'h0006_0000, 0, 0, 0, 0));
		queue_mat(make_mat(SZ_TWO, 32'h7FFF_FFFF, 32'h8000_0000, 0,
			32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 0, 0));
		queue_mat(make_mat(SZ_TWO, 1, 0, 0, 0, 1, 0, 0, 0, 0));
		queue_mat(make_mat(SZ_THREE, 32'h0001_0000, 0, 0, 0, 32'h0001_0000,
			0, 0, 0, 32'h0001_0000));
		queue_mat(make_mat(SZ_THREE, 32'h0002_0000, 32'h0001_0000, 0,
			32'h0001_0000, 32'h0003_0000, 32'h0001_0000, 0, 32'h0001_0000,
			32'h0004_0000));
		queue_mat(make_mat(SZ_THREE, 32'h0001_0000, 32'h0002_0000,
			32'h0003_0000, 32'h0004_0000, 32'h0005_0000, 32'h0006_0000,
			32'h0007_0000, 32'h0008_0000, 32'h0009_0000));
		queue_mat(make_mat(SZ_THREE, 32'h7FFF_FFFF, 32'h8000_0000,
			32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000));
		queue_mat(make_mat(SZ_THREE, 1, 0, 0, 0, 1, 0, 0, 0, 1));
		queue_mat(make_mat(SZ_NONE, 32'h0001_0000, 0, 0, 0, 32'h0001_0000,
			0, 0, 0, 32'h0001_0000));
		queue_mat(make_mat(SZ_NONE, -1, -1, -1, -1, -1, -1, -1, -1, -1));
		wait_drained();

		// long output hold while the sender keeps offering items
		@(negedge clk);
		hold_req = ~hold_req;
		run_phase(140, 0, 0);
		run_phase(140, 46, 0);
		run_phase(140, 0, 46);
		run_phase(140, 11, 11);

		repeat (TAIL) @(posedge clk);
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin
		#4000000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule
